// ----- sv/pes_pkg.sv -----
// ----------------------------------------------------------------------------
// Piecewise exponential sampler package
// Shared constants, codes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package pes_pkg;

	// Default structural sizes
	localparam int MAX_INTERVALS_DEF = 16;
	localparam int FRAC_BITS_DEF     = 16;

	// Fixed field widths
	localparam int WORD_W  = 32;
	localparam int IDX_IN_W = 4;
	localparam int CNT_W   = 5;
	localparam int ENTRY_W = 3 * WORD_W;

	// Quotient bits produced by the divider and its counter width
	localparam int QBITS   = WORD_W;
	localparam int QCNT_W  = $clog2(QBITS);

	// Item action codes
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic wr_entry;    // store one interval entry
		logic start;       // latch draw, set up search bounds
		logic issue_mid;   // read entry at search midpoint
		logic step_cmp;    // narrow search bounds from read data
		logic issue_lo;    // read entry at converged index
		logic issue_final; // pick final interval, read it
		logic load_div;    // form dividend, check saturation
		logic div_step;    // one restoring division step
		logic load_out;    // capture result into output register
	} pes_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic search_done; // lower bound reached upper bound
		logic early_sat;   // zero rate or quotient overflow
	} pes_sts_t;

endpackage

// ----- sv/pes_in_if.sv -----
// ----------------------------------------------------------------------------
// Sampler input channel
// Valid/ready channel carrying write and sample items.
// ----------------------------------------------------------------------------
interface pes_in_if;
	import pes_pkg::*;

	logic                valid;
	logic                ready;
	logic                action;
	logic [IDX_IN_W-1:0] entry_index;
	logic [WORD_W-1:0]   entry_cum_hazard;
	logic [WORD_W-1:0]   entry_start_time;
	logic [WORD_W-1:0]   entry_rate;
	logic [WORD_W-1:0]   unit_draw;

	modport source (
		output valid, action, entry_index, entry_cum_hazard, entry_start_time,
		       entry_rate, unit_draw,
		input  ready
	);

	modport sink (
		input  valid, action, entry_index, entry_cum_hazard, entry_start_time,
		       entry_rate, unit_draw,
		output ready
	);

endinterface

// ----- sv/pes_out_if.sv -----
// ----------------------------------------------------------------------------
// Sampler result channel
// Valid/ready channel carrying one sampled event time per sample item.
// ----------------------------------------------------------------------------
interface pes_out_if;
	import pes_pkg::*;

	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   sample_time;
	logic [IDX_IN_W-1:0] chosen_interval;
	logic                saturated;

	modport source (
		output valid, sample_time, chosen_interval, saturated,
		input  ready
	);

	modport sink (
		input  valid, sample_time, chosen_interval, saturated,
		output ready
	);

endinterface

// ----- sv/pes_datapath.sv -----
// ----------------------------------------------------------------------------
// Sampler datapath
// Interval entry memory, binary search bounds, restoring divider and
// result register.
// ----------------------------------------------------------------------------
module pes_datapath import pes_pkg::*; #(
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
	parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pes_cmd_t            cmd,
	output pes_sts_t            sts,
	input  logic [CNT_W-1:0]    interval_count,
	input  logic [IDX_IN_W-1:0] entry_index,
	input  logic [WORD_W-1:0]   entry_cum_hazard,
	input  logic [WORD_W-1:0]   entry_start_time,
	input  logic [WORD_W-1:0]   entry_rate,
	input  logic [WORD_W-1:0]   unit_draw,
	output logic [WORD_W-1:0]   sample_time,
	output logic [IDX_IN_W-1:0] chosen_interval,
	output logic                saturated
);

	localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int NW    = 9;

	// Entry memory: {cum_hazard, start_time, rate}
	logic [ENTRY_W-1:0] entry_mem_q [MAX_INTERVALS];
	logic [ENTRY_W-1:0] rd_q;

	logic [IDX_W-1:0]  lo_q, hi_q, mid_q, k_q;
	logic [WORD_W-1:0] draw_q;
	logic              one_q;

	logic [WORD_W-1:0] rem_q, quo_q, rate_q, start_q;
	logic              sat_q;

	// Write address, widened then cut to the memory depth
	logic [IDX_W+IDX_IN_W-1:0] wr_wide;
	logic [IDX_W-1:0]          wr_addr;
	logic                      wr_ok;

	assign wr_wide = (IDX_W+IDX_IN_W)'(entry_index);
	assign wr_addr = wr_wide[IDX_W-1:0];
	assign wr_ok   = (32'(entry_index) < 32'(MAX_INTERVALS));

	// Intervals in use, clamped to 1..MAX_INTERVALS
	logic [NW-1:0]    n_use;
	logic [NW-1:0]    n_m1;
	always_comb begin
		n_use = (interval_count == '0) ? NW'(1) : NW'(interval_count);
		if (n_use > NW'(MAX_INTERVALS))
			n_use = NW'(MAX_INTERVALS);
		n_m1 = n_use - NW'(1);
	end

	// Search midpoint
	logic [IDX_W:0]   mid_sum;
	logic [IDX_W-1:0] mid_w;
	assign mid_sum = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
	assign mid_w   = mid_sum[IDX_W-1:0];

	// Fields of the last read entry
	logic [WORD_W-1:0] rd_cum, rd_start, rd_rate;
	assign rd_cum   = rd_q[ENTRY_W-1 -: WORD_W];
	assign rd_start = rd_q[2*WORD_W-1 -: WORD_W];
	assign rd_rate  = rd_q[WORD_W-1:0];

	// Final interval: step back once if the converged entry lies above the draw
	logic [IDX_W-1:0] k_next;
	assign k_next = (rd_cum > draw_q && lo_q != '0) ? lo_q - IDX_W'(1) : lo_q;

	// Read address select
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;
	always_comb begin
		rd_en   = cmd.issue_mid | cmd.issue_lo | cmd.issue_final;
		rd_addr = lo_q;
		if (cmd.issue_mid)
			rd_addr = mid_w;
		else if (cmd.issue_final)
			rd_addr = k_next;
	end

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_entry && wr_ok)
			entry_mem_q[wr_addr] <= {entry_cum_hazard, entry_start_time, entry_rate};
		if (rd_en)
			rd_q <= entry_mem_q[rd_addr];
	end

	// Dividend and saturation check
	logic [WORD_W-1:0]   diff;
	logic [2*WORD_W-1:0] num;
	logic                div_ovf, rate_zero;
	always_comb begin
		if (one_q)
			diff = draw_q;
		else if (draw_q >= rd_cum)
			diff = draw_q - rd_cum;
		else
			diff = '0;
		num       = (2*WORD_W)'(diff) << FRAC_BITS;
		rate_zero = (rd_rate == '0);
		div_ovf   = (num >= {rd_rate, {WORD_W{1'b0}}});
	end

	assign sts.search_done = !(lo_q < hi_q);
	assign sts.early_sat   = rate_zero | div_ovf;

	// Restoring division step
	logic [WORD_W:0]   trial;
	logic              qbit;
	logic [WORD_W:0]   trial_sub;
	assign trial     = {rem_q, quo_q[WORD_W-1]};
	assign qbit      = (trial >= {1'b0, rate_q});
	assign trial_sub = trial - {1'b0, rate_q};

	// Search, division and operand registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			draw_q <= unit_draw;
			lo_q   <= '0;
			hi_q   <= n_m1[IDX_W-1:0];
			one_q  <= (n_use == NW'(1));
		end
		if (cmd.issue_mid)
			mid_q <= mid_w;
		if (cmd.step_cmp) begin
			if (rd_cum <= draw_q)
				lo_q <= mid_q + IDX_W'(1);
			else
				hi_q <= mid_q;
		end
		if (cmd.issue_final)
			k_q <= k_next;
		if (cmd.load_div) begin
			rem_q   <= num[2*WORD_W-1:WORD_W];
			quo_q   <= num[WORD_W-1:0];
			rate_q  <= rd_rate;
			start_q <= one_q ? '0 : rd_start;
			sat_q   <= rate_zero | div_ovf;
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[WORD_W-2:0], qbit};
			rem_q <= qbit ? trial_sub[WORD_W-1:0] : trial[WORD_W-1:0];
		end
	end

	// Offset by start time, saturate on carry
	logic [WORD_W:0]           sum;
	logic                      sat_out;
	logic [IDX_W+IDX_IN_W-1:0] k_wide;
	assign sum     = {1'b0, start_q} + {1'b0, quo_q};
	assign sat_out = sat_q | sum[WORD_W];
	assign k_wide  = (IDX_W+IDX_IN_W)'(k_q);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_time     <= '0;
			chosen_interval <= '0;
			saturated       <= 1'b0;
		end else if (cmd.load_out) begin
			sample_time     <= sat_out ? {WORD_W{1'b1}} : sum[WORD_W-1:0];
			chosen_interval <= k_wide[IDX_IN_W-1:0];
			saturated       <= sat_out;
		end
	end

endmodule

// ----- sv/pes_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sampler controller
// Sequences search, division and result handoff; holds the interval count.
// ----------------------------------------------------------------------------
module pes_ctrl import pes_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_action,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	output logic [CNT_W-1:0] interval_count,
	output pes_cmd_t         cmd,
	input  pes_sts_t         sts
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SEARCH = 3'd1;
	localparam logic [2:0] ST_SCMP   = 3'd2;
	localparam logic [2:0] ST_FETCH  = 3'd3;
	localparam logic [2:0] ST_LOAD   = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0]        state_q, state_d;
	logic [QCNT_W-1:0] cnt_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  count_q;
	logic              accept, slot_free;

	assign in_ready       = (state_q == ST_IDLE);
	assign accept         = in_valid && in_ready;
	assign out_valid      = out_valid_q;
	assign interval_count = count_q;
	assign slot_free      = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_action == ACT_WRITE)
					cmd.wr_entry = 1'b1;
				if (accept && in_action == ACT_SAMPLE) begin
					cmd.start = 1'b1;
					state_d   = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (sts.search_done) begin
					cmd.issue_lo = 1'b1;
					state_d      = ST_FETCH;
				end else begin
					cmd.issue_mid = 1'b1;
					state_d       = ST_SCMP;
				end
			end
			ST_SCMP: begin
				cmd.step_cmp = 1'b1;
				state_d      = ST_SEARCH;
			end
			ST_FETCH: begin
				cmd.issue_final = 1'b1;
				state_d         = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_div = 1'b1;
				state_d      = sts.early_sat ? ST_FIN : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State, divider count, output valid, interval count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			count_q     <= CNT_W'(1);
		end else begin
			state_q <= state_d;
			if (cmd.load_div)
				cnt_q <= QCNT_W'(QBITS - 1);
			else if (cmd.div_step)
				cnt_q <= cnt_q - QCNT_W'(1);
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_wr_en)
				count_q <= cfg_wr_data;
		end
	end

`ifndef SYNTHESIS
	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> slot_free)
		else $error("result loaded while output register busy");

	a_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.issue_mid, cmd.issue_lo, cmd.issue_final}))
		else $error("more than one entry read issued");

	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_FIN))
		else $error("divider did not finish after last step");

	a_sample_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_action == ACT_SAMPLE) |=> (state_q == ST_SEARCH && !in_ready))
		else $error("sample not started after acceptance");
`endif

endmodule

// ----- sv/piecewise_exponential_sampler_core.sv -----
// A zero rate or quotient overflow skips the radix-2 divider. A write item is
// stored as it is accepted. One sample is in flight at a time; a finished
// result waits in the output register. Reset clears control, sets
// interval_count to 1; tables unset.
// ----------------------------------------------------------------------------
// Piecewise exponential sampler core
// Maps a unit-exponential draw to an event time under a piecewise-constant
// hazard by binary search over interval entries and fixed-point division.
// ----------------------------------------------------------------------------
module piecewise_exponential_sampler_core import pes_pkg::*; #(
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
	parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	pes_in_if.sink           in_ch,
	pes_out_if.source        out_ch
);

	pes_cmd_t         cmd;
	pes_sts_t         sts;
	logic [CNT_W-1:0] interval_count;

	// Sequencing
	pes_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_ch.valid),
		.in_action      (in_ch.action),
		.in_ready       (in_ch.ready),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.interval_count (interval_count),
		.cmd            (cmd),
		.sts            (sts)
	);

	// Storage and arithmetic
	pes_datapath #(
		.MAX_INTERVALS (MAX_INTERVALS),
		.FRAC_BITS     (FRAC_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.interval_count   (interval_count),
		.entry_index      (in_ch.entry_index),
		.entry_cum_hazard (in_ch.entry_cum_hazard),
		.entry_start_time (in_ch.entry_start_time),
		.entry_rate       (in_ch.entry_rate),
		.unit_draw        (in_ch.unit_draw),
		.sample_time      (out_ch.sample_time),
		.chosen_interval  (out_ch.chosen_interval),
		.saturated        (out_ch.saturated)
	);

endmodule
